/* design/modular_exponentiation_unit_assert.svh */
// ----------------------------------------------------------------------------
// modular exponentiation unit assertion macros
// concurrent checks with and without reset gating
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH
`define MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH

// same-cycle implication, gated by reset
`define MEU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, gated by reset
`define MEU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, live during reset
`define MEU_ASSERT_NXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/meu_pkg.sv */
// ----------------------------------------------------------------------------
// meu_pkg
// widths, register indexes and the modular shift-add step
// ----------------------------------------------------------------------------
package meu_pkg;

    localparam int FIELD_W = 31;
    localparam int EXP_W   = 31;
    localparam int ADDR_W  = 2;

    localparam logic [ADDR_W-1:0] REG_MODULUS  = 2'd0;
    localparam logic [ADDR_W-1:0] REG_EXPONENT = 2'd1;

    localparam logic [FIELD_W-1:0] MODULUS_RESET  = 31'd2;
    localparam logic [FIELD_W-1:0] EXPONENT_RESET = 31'd1;
    localparam logic [FIELD_W-1:0] ONE            = 31'd1;

    // one step of interleaved modular multiplication: (2r + b*a) mod m, r and a below m
    function automatic logic [FIELD_W-1:0] mod_step(
        input logic [FIELD_W-1:0] r,
        input logic [FIELD_W-1:0] a,
        input logic               b,
        input logic [FIELD_W-1:0] m
    );
        logic [FIELD_W:0] t;
        t = {r, 1'b0};
        if (t >= {1'b0, m}) begin
            t = t - {1'b0, m};
        end
        if (b) begin
            t = t + {1'b0, a};
        end
        if (t >= {1'b0, m}) begin
            t = t - {1'b0, m};
        end
        return t[FIELD_W-1:0];
    endfunction

endpackage

/* design/modular_exponentiation_unit.sv */
// ----------------------------------------------------------------------------
// modular exponentiation unit
// fully pipelined base^exponent mod modulus, unless stalled one word per cycle
// ----------------------------------------------------------------------------
// Takes one word per clock and returns one word per clock once the pipeline
// is full and the output does not stall. OP_W = min(VALUE_WIDTH, 31) stages
// reduce the base one bit per stage, then each of the 31 exponent bits gets
// 31 stages of shift-add modular multiplication, squaring and accumulation
// side by side. A skid register at the output holds one finished word; while
// it waits the input is closed. The user must write modulus and exponent only
// while the unit is empty; the unit does not enforce this.
module modular_exponentiation_unit
    import meu_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [ADDR_W-1:0]   cfg_addr,
    input  logic [FIELD_W-1:0]  cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [FIELD_W-1:0]  s_base_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [FIELD_W-1:0]  m_power_result
);

    localparam int OP_W       = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
    localparam int MUL_STAGES = EXP_W * FIELD_W;
    localparam int LAST       = MUL_STAGES - 1;

    logic [FIELD_W-1:0] modulus_reg;
    logic [FIELD_W-1:0] exponent_reg;

    logic               en;

    logic               rv_reg  [OP_W];
    logic [OP_W-1:0]    rb_reg  [OP_W];
    logic [FIELD_W-1:0] rr_reg  [OP_W];

    logic               mv_reg  [MUL_STAGES];
    logic [FIELD_W-1:0] ma_reg  [MUL_STAGES];
    logic [FIELD_W-1:0] mq_reg  [MUL_STAGES];
    logic [FIELD_W-1:0] mra_reg [MUL_STAGES];
    logic [FIELD_W-1:0] mrs_reg [MUL_STAGES];

    logic               skid_valid_reg;
    logic [FIELD_W-1:0] skid_data_reg;
    logic [FIELD_W-1:0] final_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg  <= MODULUS_RESET;
            exponent_reg <= EXPONENT_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_MODULUS:  modulus_reg  <= cfg_wdata;
                REG_EXPONENT: exponent_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // base reduction, one bit per stage from the top
    for (genvar i = 0; i < OP_W; i++) begin : g_red
        logic               vin;
        logic [OP_W-1:0]    bin;
        logic [FIELD_W-1:0] rin;
        if (i == 0) begin : g_first
            assign vin = s_valid;
            assign bin = s_base_value[OP_W-1:0];
            assign rin = '0;
        end else begin : g_rest
            assign vin = rv_reg[i-1];
            assign bin = rb_reg[i-1];
            assign rin = rr_reg[i-1];
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rv_reg[i] <= 1'b0;
            end else if (en) begin
                rv_reg[i] <= vin;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rb_reg[i] <= bin;
                rr_reg[i] <= mod_step(rin, ONE, bin[OP_W-1-i], modulus_reg);
            end
        end
    end

    // square-and-multiply, 31 stages per exponent bit
    for (genvar s = 0; s < MUL_STAGES; s++) begin : g_mul
        localparam int G = s / FIELD_W;
        localparam int K = s % FIELD_W;
        logic               vin;
        logic [FIELD_W-1:0] ain;
        logic [FIELD_W-1:0] qin;
        logic [FIELD_W-1:0] rain;
        logic [FIELD_W-1:0] rsin;
        logic [FIELD_W-1:0] ra_next;
        logic [FIELD_W-1:0] rs_next;
        if (s == 0) begin : g_first
            assign vin  = rv_reg[OP_W-1];
            assign ain  = (modulus_reg == ONE) ? '0 : ONE;
            assign qin  = rr_reg[OP_W-1];
            assign rain = '0;
            assign rsin = '0;
        end else begin : g_rest
            assign vin  = mv_reg[s-1];
            assign ain  = ma_reg[s-1];
            assign qin  = mq_reg[s-1];
            assign rain = mra_reg[s-1];
            assign rsin = mrs_reg[s-1];
        end
        assign ra_next = mod_step(rain, ain, qin[FIELD_W-1-K], modulus_reg);
        assign rs_next = mod_step(rsin, qin, qin[FIELD_W-1-K], modulus_reg);
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                mv_reg[s] <= 1'b0;
            end else if (en) begin
                mv_reg[s] <= vin;
            end
        end
        if (K == FIELD_W - 1) begin : g_close
            // products complete: fold in the exponent bit
            always_ff @(posedge aclk) begin
                if (en) begin
                    ma_reg[s]  <= exponent_reg[G] ? ra_next : ain;
                    mq_reg[s]  <= rs_next;
                    mra_reg[s] <= '0;
                    mrs_reg[s] <= '0;
                end
            end
        end else begin : g_step
            always_ff @(posedge aclk) begin
                if (en) begin
                    ma_reg[s]  <= ain;
                    mq_reg[s]  <= qin;
                    mra_reg[s] <= ra_next;
                    mrs_reg[s] <= rs_next;
                end
            end
        end
    end

    assign final_result = (modulus_reg == '0) ? '0 : ma_reg[LAST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (en) begin
            skid_valid_reg <= mv_reg[LAST] && !m_ready;
        end else if (m_ready) begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            skid_data_reg <= final_result;
        end
    end

    assign m_valid        = skid_valid_reg || mv_reg[LAST];
    assign m_power_result = skid_valid_reg ? skid_data_reg : final_result;

endmodule

/* design/meu_checker.sv */
// ----------------------------------------------------------------------------
// meu_checker
// port-level checks on the modular exponentiation unit
// ----------------------------------------------------------------------------
`include "modular_exponentiation_unit_assert.svh"

module meu_checker
    import meu_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [FIELD_W-1:0] m_power_result
);

    // a held word stays offered
    `MEU_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "output word dropped")

    // input only closes when a finished word is backed up
    `MEU_ASSERT_IMP(a_ready_low, aclk, aresetn, !s_ready, m_valid, "input stalled with no word waiting")

    // a residue is always below the largest modulus
    `MEU_ASSERT_IMP(a_range, aclk, aresetn, m_valid, m_power_result != 31'h7FFF_FFFF, "result out of range")

    // nothing comes out straight after reset
    `MEU_ASSERT_NXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid, "output valid after reset")

endmodule

bind modular_exponentiation_unit meu_checker u_meu_checker (.*);

/* tb/modular_exponentiation_unit_tb.sv */
// ----------------------------------------------------------------------------
// modular exponentiation unit testbench
// drives words through the pipeline under several keys and idling mixes and
// checks every result against a square-and-multiply predictor in order
// ----------------------------------------------------------------------------
module modular_exponentiation_unit_tb;
    import meu_pkg::*;

    localparam int LATENCY     = 31 + 31 * 31;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [ADDR_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [ADDR_W-1:0] REG_SPARE_3 = 2'd3;
    localparam logic [FIELD_W-1:0] FIELD_MAX  = 31'h7fffffff;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [ADDR_W-1:0]  cfg_addr = '0;
    logic [FIELD_W-1:0] cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [FIELD_W-1:0] s_base_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [FIELD_W-1:0] m_power_result;

    logic [FIELD_W-1:0] key_modulus = MODULUS_RESET;
    logic [FIELD_W-1:0] key_exp = EXPONENT_RESET;
    logic [FIELD_W-1:0] pending_powers[$];
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 hold_off_cycles = 0;
    int                 mismatches = 0;
    int                 cycle_count = 0;

    modular_exponentiation_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_base_value(s_base_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_power_result(m_power_result)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [FIELD_W-1:0] power_mod(input logic [FIELD_W-1:0] base);
        longint unsigned acc, sq, e, m;
        m = 64'(key_modulus);
        if (m == 0) return '0;
        acc = 1 % m;
        sq = 64'(base) % m;
        e = 64'(key_exp);
        while (e != 0) begin
            if (e[0]) acc = (acc * sq) % m;
            sq = (sq * sq) % m;
            e = e >> 1;
        end
        return acc[FIELD_W-1:0];
    endfunction

    // result checker and receiver idling
    always @(posedge aclk) begin
        logic [FIELD_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_powers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: got %0d", m_power_result);
            end else begin
                want = pending_powers.pop_front();
                if (m_power_result !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("power_result mismatch: expected %0d, got %0d",
                                 want, m_power_result);
                end
            end
        end
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [FIELD_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_MODULUS) key_modulus = val;
        else if (idx == REG_EXPONENT) key_exp = val;
    endtask

    task automatic send_word(input logic [FIELD_W-1:0] base);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_base_value <= base;
        pending_powers.push_back(power_mod(base));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (pending_powers.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic logic [FIELD_W-1:0] random_base();
        case ($urandom_range(3))
            0: return FIELD_W'($urandom_range(255));
            1: return FIELD_W'(key_modulus + $urandom_range(3) - 2);
            default: return FIELD_W'($urandom() & FIELD_MAX);
        endcase
    endfunction

    task automatic test_reset_key();
        send_word(31'd0);
        send_word(31'd1);
        send_word(31'd2);
        send_word(FIELD_MAX);
        drain_pipeline();
    endtask

    task automatic test_extremes();
        write_reg(REG_MODULUS, FIELD_MAX);
        write_reg(REG_EXPONENT, FIELD_MAX);
        send_word(31'd0);
        send_word(31'd1);
        send_word(FIELD_MAX);
        send_word(FIELD_MAX - 31'd1);
        send_word(31'h55555555);
        send_word(31'h2aaaaaaa);
        drain_pipeline();
        // exponent zero gives one
        write_reg(REG_EXPONENT, '0);
        send_word(31'd0);
        send_word(31'd12345);
        send_word(FIELD_MAX);
        drain_pipeline();
    endtask

    task automatic test_degenerate_moduli();
        write_reg(REG_EXPONENT, 31'd65537);
        write_reg(REG_MODULUS, 31'd1);
        send_word(31'd7);
        send_word(FIELD_MAX);
        drain_pipeline();
        write_reg(REG_EXPONENT, '0);
        send_word(31'd9);
        drain_pipeline();
        write_reg(REG_MODULUS, 31'd0);
        send_word(31'd3);
        drain_pipeline();
        write_reg(REG_EXPONENT, 31'd5);
        send_word(31'd3);
        send_word(FIELD_MAX);
        drain_pipeline();
    endtask

    task automatic test_spare_indexes();
        write_reg(REG_MODULUS, 31'd3233);
        write_reg(REG_EXPONENT, 31'd17);
        write_reg(REG_SPARE_2, 31'h7fff0000);
        write_reg(REG_SPARE_3, 31'h0000ffff);
        send_word(31'd65);
        send_word(31'd3232);
        send_word(31'd3233);
        drain_pipeline();
    endtask

    task automatic run_phase(input int n, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) send_word(random_base());
        drain_pipeline();
    endtask

    task automatic test_random_keys();
        int k;
        for (k = 0; k < 6; k++) begin
            write_reg(REG_MODULUS,
                      (k == 0) ? FIELD_MAX : FIELD_W'(($urandom() & FIELD_MAX) | 32'd2));
            write_reg(REG_EXPONENT,
                      (k == 1) ? FIELD_MAX : FIELD_W'($urandom() & FIELD_MAX));
            case (k % 4)
                0: run_phase(6, 0, 0);
                1: run_phase(6, 56, 0);
                2: run_phase(6, 0, 56);
                default: run_phase(6, 23, 23);
            endcase
        end
    endtask

    task automatic test_backpressure();
        write_reg(REG_MODULUS, 31'd2147483629);
        write_reg(REG_EXPONENT, FIELD_W'(($urandom() & FIELD_MAX) | 32'd1));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // long receiver hold-off fills the pipe and stalls the input
        hold_off_cycles = 3 * LATENCY;
        repeat (1000) send_word(random_base());
        drain_pipeline();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_key();
        test_extremes();
        test_degenerate_moduli();
        test_spare_indexes();
        test_random_keys();
        test_backpressure();
        drain_pipeline();
        repeat (LATENCY + 50) @(posedge aclk);
        if (mismatches == 0 && pending_powers.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
